@@ hdl/ppid_pkg.sv @@
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared types, widths and register indexes of the positional PID controller.
// ----------------------------------------------------------------------------
package ppid_pkg;

   // Configuration register indexes.
   localparam logic [2:0] REG_GAIN_P    = 3'd0;
   localparam logic [2:0] REG_GAIN_I    = 3'd1;
   localparam logic [2:0] REG_GAIN_D    = 3'd2;
   localparam logic [2:0] REG_DEAD_BAND = 3'd3;
   localparam logic [2:0] REG_INT_THR   = 3'd4;
   localparam logic [2:0] REG_INT_LIM   = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Largest drive magnitude; the most negative code is never produced.
   localparam logic signed [31:0] DRIVE_MAX = 32'sh7FFF_FFFF;

   localparam logic [16:0] INT_THR_RESET = 17'h1_FFFF;
   localparam logic [30:0] INT_LIM_RESET = 31'h7FFF_FFFF;

   typedef struct packed {
      logic signed [15:0] gain_proportional;
      logic signed [15:0] gain_integral;
      logic signed [15:0] gain_derivative;
      logic        [15:0] dead_band;
      logic        [16:0] integral_threshold;
      logic        [30:0] integral_limit;
   } ppid_cfg_type;

   // Error stage result: dead-banded error, its difference, clamped integral.
   typedef struct packed {
      logic signed [16:0] err;
      logic signed [17:0] err_diff;
      logic signed [31:0] integral;
      logic               sat;
   } ppid_mid_type;

   // Product stage result.
   typedef struct packed {
      logic signed [32:0] prod_p;
      logic signed [47:0] prod_i;
      logic signed [33:0] prod_d;
      logic               sat;
   } ppid_prod_type;

endpackage

@@ hdl/ppid_err.sv @@
// ----------------------------------------------------------------------------
// ppid_err
// Error, dead band, integral separation and integral clamp; holds the state.
// ----------------------------------------------------------------------------
module ppid_err
   import ppid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ppid_cfg_type       cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [15:0] measured,
   input  logic signed [15:0] target,
   output logic               mid_valid,
   input  logic               mid_ready,
   output ppid_mid_type       mid
);

   logic               mid_valid_ff, mid_valid_in;
   ppid_mid_type       mid_ff, mid_in;
   logic signed [31:0] integral_ff, integral_in;
   logic signed [16:0] prev_err_ff, prev_err_in;

   logic signed [16:0] err_raw;
   logic signed [16:0] err_abs;
   logic        [15:0] mag;
   logic               dead;
   logic               integrate;
   logic signed [16:0] err_db;
   logic        [15:0] shrunk;
   logic signed [16:0] shrunk_s;
   logic signed [16:0] delta;
   logic signed [32:0] acc_raw;
   logic signed [32:0] lim;
   logic signed [32:0] lim_neg;
   logic               over_hi;
   logic               over_lo;
   logic               take;

   assign in_ready = !mid_valid_ff || mid_ready;
   assign take     = in_valid && in_ready;

   assign err_raw = 17'(target) - 17'(measured);
   assign err_abs = err_raw[16] ? -err_raw : err_raw;
   // |error| is at most 65535, so 16 bits hold it.
   assign mag     = err_abs[15:0];
   assign dead    = mag < cfg.dead_band;
   assign err_db  = dead ? 17'sd0 : err_raw;

   // Outside the dead band mag >= dead_band, so this cannot wrap.
   assign shrunk    = mag - cfg.dead_band;
   assign shrunk_s  = $signed({1'b0, shrunk});
   assign integrate = !dead && ({1'b0, mag} < cfg.integral_threshold);
   assign delta     = !integrate ? 17'sd0 : (err_raw[16] ? -shrunk_s : shrunk_s);

   assign acc_raw = 33'(integral_ff) + 33'(delta);
   assign lim     = $signed({2'b00, cfg.integral_limit});
   assign lim_neg = -lim;
   assign over_hi = acc_raw > lim;
   assign over_lo = acc_raw < lim_neg;

   always_comb begin
      mid_in.err      = err_db;
      mid_in.err_diff = 18'(err_db) - 18'(prev_err_ff);
      mid_in.sat      = over_hi || over_lo;
      if (over_hi) begin
         mid_in.integral = lim[31:0];
      end else if (over_lo) begin
         mid_in.integral = lim_neg[31:0];
      end else begin
         mid_in.integral = acc_raw[31:0];
      end
   end

   assign mid_valid_in = take ? 1'b1 : (mid_ready ? 1'b0 : mid_valid_ff);
   assign integral_in  = take ? mid_in.integral : integral_ff;
   assign prev_err_in  = take ? err_db : prev_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         integral_ff  <= '0;
         prev_err_ff  <= '0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         integral_ff  <= integral_in;
         prev_err_ff  <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid       = mid_ff;

   // The stored integral never leaves the limit that was in force when set.
   a_int_in_limit: assert property (@(posedge clock) disable iff (reset)
      take |=> ($signed(integral_ff) <= $signed({1'b0, $past(cfg.integral_limit)}))
               && ($signed(integral_ff) >= -$signed({1'b0, $past(cfg.integral_limit)})))
      else $error("integral outside limit");

   // An error inside the dead band is passed on as zero.
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      (take && dead) |=> (mid_ff.err == 17'sd0))
      else $error("dead band error not zeroed");

   // The previous error tracks the error handed to the next stage.
   a_prev_track: assert property (@(posedge clock) disable iff (reset)
      take |=> (prev_err_ff == mid_ff.err))
      else $error("previous error out of step");

endmodule

@@ hdl/ppid_mult.sv @@
// ----------------------------------------------------------------------------
// ppid_mult
// Three gain multiplies, registered.
// ----------------------------------------------------------------------------
module ppid_mult
   import ppid_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ppid_cfg_type  cfg,
   input  logic          mid_valid,
   output logic          mid_ready,
   input  ppid_mid_type  mid,
   output logic          prod_valid,
   input  logic          prod_ready,
   output ppid_prod_type prod
);

   logic          prod_valid_ff, prod_valid_in;
   ppid_prod_type prod_ff, prod_in;
   logic          take;

   assign mid_ready = !prod_valid_ff || prod_ready;
   assign take      = mid_valid && mid_ready;

   always_comb begin
      prod_in.prod_p = 33'(cfg.gain_proportional) * 33'(mid.err);
      prod_in.prod_i = 48'(cfg.gain_integral) * 48'(mid.integral);
      prod_in.prod_d = 34'(cfg.gain_derivative) * 34'(mid.err_diff);
      prod_in.sat    = mid.sat;
   end

   assign prod_valid_in = take ? 1'b1 : (prod_ready ? 1'b0 : prod_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = prod_valid_ff;
   assign prod       = prod_ff;

   // A held product stage keeps its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (prod_valid_ff && !prod_ready) |=> (prod_valid_ff && $stable(prod_ff)))
      else $error("product stage lost while stalled");

   // A zero proportional gain gives a zero proportional product.
   a_zero_gain: assert property (@(posedge clock) disable iff (reset)
      (take && cfg.gain_proportional == 16'sd0) |=> (prod_ff.prod_p == 33'sd0))
      else $error("proportional product not zero");

   // The integral product fits in 46 bits plus sign.
   a_prod_range: assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff |-> (prod_ff.prod_i[47] == prod_ff.prod_i[46]))
      else $error("integral product out of range");

endmodule

@@ hdl/ppid_out.sv @@
// ----------------------------------------------------------------------------
// ppid_out
// Sum of products, floor shift by 8, saturation, result register.
// ----------------------------------------------------------------------------
module ppid_out
   import ppid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               prod_valid,
   output logic               prod_ready,
   input  ppid_prod_type      prod,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive,
   output logic               rsp_saturated
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] drive_ff, drive_in;
   logic               sat_ff, sat_in;
   logic signed [49:0] sum;
   logic signed [41:0] shifted;
   logic               over_hi;
   logic               over_lo;
   logic               take;

   assign prod_ready = !rsp_valid_ff || rsp_ready;
   assign take       = prod_valid && prod_ready;

   assign sum     = 50'(prod.prod_p) + 50'(prod.prod_i) + 50'(prod.prod_d);
   // Dropping the low bits of a two's complement value rounds toward minus infinity.
   assign shifted = sum[49:8];
   assign over_hi = shifted > 42'(DRIVE_MAX);
   assign over_lo = shifted < -42'(DRIVE_MAX);

   always_comb begin
      sat_in = prod.sat || over_hi || over_lo;
      if (over_hi) begin
         drive_in = DRIVE_MAX;
      end else if (over_lo) begin
         drive_in = -DRIVE_MAX;
      end else begin
         drive_in = shifted[31:0];
      end
   end

   assign rsp_valid_in = take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         drive_ff <= drive_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = drive_ff;
   assign rsp_saturated = sat_ff;

   // The most negative code is never driven.
   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (drive_ff != 32'sh8000_0000))
      else $error("drive reached the most negative code");

   // A clipped drive is always flagged.
   a_clip_flag: assert property (@(posedge clock) disable iff (reset)
      (take && (over_hi || over_lo)) |=> sat_ff)
      else $error("clipped drive not flagged");

   // Each taken product becomes a pending result.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("result lost");

endmodule

@@ hdl/positional_pid_deadband.sv @@
// ----------------------------------------------------------------------------
// positional_pid_deadband
// Positional PID controller with error dead band and integral separation.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_measured, req_target
//   rsp_      out        rsp_valid/rsp_ready   rsp_drive, rsp_saturated
//   csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// A request passes four registers: the input register, the error stage
// (which also updates the integral and previous error), the product stage
// and the result register, in that order, before its result is presented.
// One request is accepted every cycle while the output side keeps up; the
// throughput is set by the integral add-and-clamp loop in the error stage.
// Each stage only waits when the stage after it is full and stalled, so
// bubbles are squeezed out under back-pressure. Reset is synchronous and
// active high; it clears every valid flag, the integral and previous error,
// and loads the register defaults. Writes to the CSR port are always taken;
// an index beyond the register list is ignored.
//
module positional_pid_deadband
   import ppid_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_measured,
   input  logic signed [15:0]     req_target,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_drive,
   output logic                   rsp_saturated,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers.
   ppid_cfg_type cfg_ff, cfg_in;

   // Input register.
   logic               in_valid_ff, in_valid_in;
   logic signed [15:0] measured_ff;
   logic signed [15:0] target_ff;

   logic          err_ready;
   logic          mid_valid;
   logic          mid_ready;
   ppid_mid_type  mid;
   logic          prod_valid;
   logic          prod_ready;
   ppid_prod_type prod;
   logic          req_take;

   // The CSR port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_GAIN_P:    cfg_in.gain_proportional  = $signed(csr_data[15:0]);
            REG_GAIN_I:    cfg_in.gain_integral      = $signed(csr_data[15:0]);
            REG_GAIN_D:    cfg_in.gain_derivative    = $signed(csr_data[15:0]);
            REG_DEAD_BAND: cfg_in.dead_band          = csr_data[15:0];
            REG_INT_THR:   cfg_in.integral_threshold = csr_data[16:0];
            REG_INT_LIM:   cfg_in.integral_limit     = csr_data[30:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_proportional  <= '0;
         cfg_ff.gain_integral      <= '0;
         cfg_ff.gain_derivative    <= '0;
         cfg_ff.dead_band          <= '0;
         cfg_ff.integral_threshold <= INT_THR_RESET;
         cfg_ff.integral_limit     <= INT_LIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The input register takes a new request whenever it is empty or its
   // current request moves on into the error stage in the same cycle.
   assign req_ready   = !in_valid_ff || err_ready;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take ? 1'b1 : (err_ready ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         measured_ff <= req_measured;
         target_ff   <= req_target;
      end
   end

   // Error, dead band and integral update; the controller state lives here.
   ppid_err u_err (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (in_valid_ff),
      .in_ready  (err_ready),
      .measured  (measured_ff),
      .target    (target_ff),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid       (mid)
   );

   // The three gain products.
   ppid_mult u_mult (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .mid_valid  (mid_valid),
      .mid_ready  (mid_ready),
      .mid        (mid),
      .prod_valid (prod_valid),
      .prod_ready (prod_ready),
      .prod       (prod)
   );

   // Sum, scaling, saturation and the result register.
   ppid_out u_out (
      .clock         (clock),
      .reset         (reset),
      .prod_valid    (prod_valid),
      .prod_ready    (prod_ready),
      .prod          (prod),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive     (rsp_drive),
      .rsp_saturated (rsp_saturated)
   );

   // An accepted request always lands in the input register.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("request not captured");

   // A request held in a stalled input register keeps its payload.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !err_ready) |=> (in_valid_ff && $stable(measured_ff)
                                       && $stable(target_ff)))
      else $error("input register changed while stalled");

   // Register writes beyond the list leave the configuration unchanged.
   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index != REG_GAIN_P && csr_index != REG_GAIN_I
       && csr_index != REG_GAIN_D && csr_index != REG_DEAD_BAND
       && csr_index != REG_INT_THR && csr_index != REG_INT_LIM) |=> $stable(cfg_ff))
      else $error("configuration changed by unknown index");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional PID controller with dead band.
// A short directed table pins down reset behavior, gain extremes, the dead
// band, the integral clamp and floor rounding. It is followed by random
// phases, two of them driving the integral into wind-up. Every response is
// compared in order against a software copy of the controller.
// ----------------------------------------------------------------------------
module tb
   import ppid_pkg::*;
();

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 6;
   localparam int PIPE_DEPTH    = 4;
   localparam int MAX_GAP       = 20;
   localparam int LIMIT_NS      = 4_000_000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_SAMPLES = 100;
   localparam int WINDUP_SAMPLES = 450;
   localparam int UNWIND_SAMPLES = 60;
   localparam int ROW_COUNT     = 34;

   // Indexes past the end of the register file; writes to them must be dropped.
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   localparam logic signed [15:0] S_MIN = 16'sh8000;
   localparam logic signed [15:0] S_MAX = 16'sh7FFF;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               sat;
   } pid_out_type;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;

   // One line of the directed table: a register write or a sample. Samples
   // marked typed carry a hand-computed response; the rest use the predictor.
   typedef struct packed {
      row_kind_type       kind;
      logic [2:0]         index;
      logic [31:0]        data;
      logic signed [15:0] measured;
      logic signed [15:0] target;
      logic               typed;
      logic signed [31:0] drive;
      logic               sat;
   } stim_row_type;

   // ---------------------------------------------------------------------
   // Block ports. Every input holds a known value from time zero.
   // ---------------------------------------------------------------------
   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   logic signed [15:0]     req_measured = '0;
   logic signed [15:0]     req_target   = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   logic signed [31:0]     rsp_drive;
   logic                   rsp_saturated;
   logic                   csr_valid    = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_data     = '0;

   positional_pid_deadband uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_measured  (req_measured),
      .req_target    (req_target),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive     (rsp_drive),
      .rsp_saturated (rsp_saturated),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the controller: its registers and its two state words.
   // ---------------------------------------------------------------------
   int     kp, ki, kd;
   longint dead_band, int_threshold, int_limit;
   int     prev_err, integ;

   pid_out_type drive_queue[$];   // responses owed by the block, oldest first

   int sender_gap_pct     = 0;
   int receiver_stall_pct = 0;
   int errors             = 0;
   int samples_sent       = 0;
   int reg_writes         = 0;
   int responses_checked  = 0;
   int saturated_seen     = 0;

   function automatic void reset_shadow();
      kp            = 0;
      ki            = 0;
      kd            = 0;
      dead_band     = 0;
      int_threshold = INT_THR_RESET;
      int_limit     = INT_LIM_RESET;
      prev_err      = 0;
      integ         = 0;
   endfunction

   // Register writes keep only the low bits that each register holds.
   function automatic void apply_reg(input logic [2:0] index, input logic [31:0] data);
      case (index)
         REG_GAIN_P:    kp = $signed(data[15:0]);
         REG_GAIN_I:    ki = $signed(data[15:0]);
         REG_GAIN_D:    kd = $signed(data[15:0]);
         REG_DEAD_BAND: dead_band = data[15:0];
         REG_INT_THR:   int_threshold = data[16:0];
         REG_INT_LIM:   int_limit = data[30:0];
         default: ;
      endcase
   endfunction

   // One controller sample: dead band, separated integration, integral
   // clamp, Q8.8 gains, a floor-shifted sum, then output saturation. Advances
   // the shadow state exactly as the block does on acceptance.
   function automatic pid_out_type compute_drive(input logic signed [15:0] meas,
                                                 input logic signed [15:0] tgt);
      int          err, mag;
      longint      acc, sum, d;
      pid_out_type r;
      r.sat = 1'b0;
      err = int'(tgt) - int'(meas);
      mag = (err < 0) ? -err : err;
      if (mag < dead_band) begin
         err = 0;
         mag = 0;
      end
      // The integral moves by the error shrunk toward zero by the dead band;
      // a zeroed error leaves it alone, but the clamp below always applies.
      acc = integ;
      if (mag < int_threshold) begin
         if (err < 0)
            acc = acc + err + dead_band;
         else if (err > 0)
            acc = acc + err - dead_band;
      end
      if (acc > int_limit) begin
         acc   = int_limit;
         r.sat = 1'b1;
      end else if (acc < -int_limit) begin
         acc   = -int_limit;
         r.sat = 1'b1;
      end
      integ = int'(acc);
      sum = longint'(kp) * err + longint'(ki) * acc
          + longint'(kd) * (longint'(err) - prev_err);
      d = sum >>> 8;   // arithmetic shift, so negative sums round down
      if (d > longint'(DRIVE_MAX)) begin
         d     = DRIVE_MAX;
         r.sat = 1'b1;
      end else if (d < -longint'(DRIVE_MAX)) begin
         d     = -longint'(DRIVE_MAX);
         r.sat = 1'b1;
      end
      r.drive  = 32'(d);
      prev_err = err;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Random value pickers. Each leans on the extremes of its register.
   // ---------------------------------------------------------------------
   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 32'h0000_7FFF;
         1: return 32'hFFFF_8000;
         2: return 32'h0000_0000;
         3: return {16'($urandom), 16'($urandom_range(0, 512) - 256)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_band();
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'h0000_FFFF;
         2: return $urandom_range(0, 300);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_threshold();
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'h0001_FFFF;
         2: return $urandom_range(0, 2000);
         3: return $urandom_range(0, 70000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 50000);
         3: return $urandom_range(0, 5_000_000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [15:0] pick_extreme();
      case ($urandom_range(0, 3))
         0: return S_MIN;
         1: return S_MAX;
         2: return 16'sd0;
         default: return -16'sd1;
      endcase
   endfunction

   // A random pair of inputs. Besides uniform values it aims the error just
   // around the dead band and the integration threshold, where the behavior
   // changes, and at the corners of the input range.
   function automatic void random_pair(output logic signed [15:0] meas,
                                       output logic signed [15:0] tgt);
      int off, v;
      meas = 16'($urandom);
      tgt  = 16'($urandom);
      case ($urandom_range(0, 5))
         2, 3: begin
            off = $urandom_range(0, 2);
            off = off - 1 + int'(($urandom_range(0, 1) == 0) ? dead_band : int_threshold);
            v = ($urandom_range(0, 1) == 0) ? int'(meas) + off : int'(meas) - off;
            if (v > 32767)
               v = 32767;
            else if (v < -32768)
               v = -32768;
            tgt = 16'(v);
         end
         4: begin
            meas = pick_extreme();
            tgt  = pick_extreme();
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers. All of them are entered and left on a rising edge,
   // drive with nonblocking assignments there, and look at ready on the
   // falling edge, where nothing is in motion.
   // ---------------------------------------------------------------------

   // Offer one request. Valid from the previous request is left high when
   // there is no gap, so back-to-back requests never toggle it in one step.
   task automatic send_sample(input logic signed [15:0] meas,
                              input logic signed [15:0] tgt,
                              input pid_out_type want);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < sender_gap_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      drive_queue.push_back(want);
      req_valid    <= 1'b1;
      req_measured <= meas;
      req_target   <= tgt;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      samples_sent++;
   endtask

   // Drop valid and wait until every owed response has been seen. The block
   // is empty afterwards, so registers may be written.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drive_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(negedge clock); while (!csr_ready);
      apply_reg(index, data);
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

   // Response checker: each accepted response is matched against the oldest
   // owed one, field by field.
   always @(negedge clock) begin : check_responses
      pid_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_checked++;
         if (rsp_saturated)
            saturated_seen++;
         if (drive_queue.size() == 0) begin
            $error("unexpected response: drive %0d, saturated %0b", rsp_drive, rsp_saturated);
            errors++;
         end else begin
            want = drive_queue.pop_front();
            if (rsp_drive !== want.drive) begin
               $error("drive mismatch: expected %0d, actual %0d", want.drive, rsp_drive);
               errors++;
            end
            if (rsp_saturated !== want.sat) begin
               $error("saturated mismatch: expected %0b, actual %0b", want.sat,
                      rsp_saturated);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed table. Typed responses follow straight from the inputs: with
   // all gains at zero nothing comes out, and with a single proportional
   // gain the response is Kp*e shifted down by eight, rounding down.
   // ---------------------------------------------------------------------
   stim_row_type directed_rows [ROW_COUNT] = '{
      // Out of reset every gain is zero.
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd0, 16'sd0, 1'b1, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, S_MIN, S_MAX, 1'b1, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, S_MAX, S_MIN, 1'b1, 32'sd0, 1'b0},
      // Largest positive proportional gain on the largest errors.
      '{ROW_WRITE, REG_GAIN_P, 32'h0000_7FFF, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, S_MIN, S_MAX, 1'b1, 32'sd8388224, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, S_MAX, S_MIN, 1'b1, -32'sd8388225, 1'b0},
      // Most negative gain; the upper data bits are junk and must be dropped.
      '{ROW_WRITE, REG_GAIN_P, 32'hA5A5_8000, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, S_MIN, S_MAX, 1'b1, -32'sd8388480, 1'b0},
      // Dead band of 100: an error of 99 vanishes, 100 passes through.
      '{ROW_WRITE, REG_DEAD_BAND, 32'd100, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd0, 16'sd99, 1'b1, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd0, 16'sd100, 1'b1, -32'sd12800, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd0, -16'sd100, 1'b1, 32'sd12800, 1'b0},
      // Integral and derivative terms come in.
      '{ROW_WRITE, REG_GAIN_I, 32'h0000_0100, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_WRITE, REG_GAIN_D, 32'h0000_7FFF, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd1000, -16'sd5000, 1'b0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, -16'sd20000, 16'sd20000, 1'b0, 32'sd0, 1'b0},
      // Integration off, then the limit lowered: the stored integral is
      // clamped on the next sample anyway and flagged.
      '{ROW_WRITE, REG_INT_THR, 32'd0, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_WRITE, REG_INT_LIM, 32'd1000, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_WRITE, REG_INT_LIM, 32'd0, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd5, 16'sd300, 1'b0, 32'sd0, 1'b0},
      // Threshold and limit at their tops via all-ones data, widest band.
      '{ROW_WRITE, REG_INT_THR, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_WRITE, REG_INT_LIM, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_WRITE, REG_DEAD_BAND, 32'h0000_FFFF, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      // Writes past the register file change nothing.
      '{ROW_WRITE, REG_SPARE_LO, 32'h1234_5678, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_WRITE, REG_SPARE_HI, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, S_MIN, S_MAX, 1'b0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd0, 16'sd1000, 1'b0, 32'sd0, 1'b0},
      // Unit proportional gain alone: negative sums round down.
      '{ROW_WRITE, REG_GAIN_P, 32'd1, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_WRITE, REG_GAIN_I, 32'd0, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_WRITE, REG_GAIN_D, 32'd0, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_WRITE, REG_DEAD_BAND, 32'd0, 16'sd0, 16'sd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd1, 16'sd0, 1'b1, -32'sd1, 1'b0},
      '{ROW_SAMPLE, 3'd0, 32'd0, 16'sd0, -16'sd257, 1'b1, -32'sd2, 1'b0}
   };

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic signed [15:0] meas, tgt;
      pid_out_type        want;
      int                 count;
      reset_shadow();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The directed table runs with no idling on either side.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain();
            write_reg(directed_rows[i].index, directed_rows[i].data);
         end else begin
            want = compute_drive(directed_rows[i].measured, directed_rows[i].target);
            if (directed_rows[i].typed)
               want = '{directed_rows[i].drive, directed_rows[i].sat};
            send_sample(directed_rows[i].measured, directed_rows[i].target, want);
         end
      end

      // Random phases. The first winds the integral up with a large positive
      // integral gain and a steady positive error until the drive saturates;
      // the second flips the gain sign so it saturates the other way. The
      // rest draw fresh settings. Idling rotates through none, a sluggish
      // sender, a stalling receiver, and light idling on both sides.
      for (int phase = 0; phase < RANDOM_PHASES + 2; phase++) begin
         drain();
         case (phase % 4)
            0: begin
               sender_gap_pct     = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_gap_pct     = 49;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_gap_pct     = 0;
               receiver_stall_pct = 49;
            end
            default: begin
               sender_gap_pct     = 6;
               receiver_stall_pct = 6;
            end
         endcase
         if (phase == 0) begin
            write_reg(REG_GAIN_P, pick_gain());
            write_reg(REG_GAIN_I, 32'h0000_7FFF);
            write_reg(REG_GAIN_D, pick_gain());
            write_reg(REG_DEAD_BAND, 32'd0);
            write_reg(REG_INT_THR, 32'h0001_FFFF);
            write_reg(REG_INT_LIM, 32'h7FFF_FFFF);
            count = WINDUP_SAMPLES;
         end else if (phase == 1) begin
            write_reg(REG_GAIN_I, 32'h0000_8000);
            count = UNWIND_SAMPLES;
         end else begin
            write_reg(REG_GAIN_P, pick_gain());
            write_reg(REG_GAIN_I, pick_gain());
            write_reg(REG_GAIN_D, pick_gain());
            write_reg(REG_DEAD_BAND, pick_band());
            write_reg(REG_INT_THR, pick_threshold());
            write_reg(REG_INT_LIM, pick_limit());
            if ($urandom_range(0, 3) == 0)
               write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
            count = PHASE_SAMPLES;
         end
         for (int n = 0; n < count; n++) begin
            // Halfway through each phase the sender holds off until the
            // block has handed back everything it owes.
            if (n == count / 2)
               drain();
            if (phase < 2) begin
               meas = 16'(int'($urandom_range(0, 16383)) - 32768);
               tgt  = 16'($urandom_range(16384, 32767));
            end else begin
               random_pair(meas, tgt);
            end
            want = compute_drive(meas, tgt);
            send_sample(meas, tgt, want);
         end
      end

      drain();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (drive_queue.size() != 0) begin
         $error("%0d responses never arrived", drive_queue.size());
         errors++;
      end
      $display("tb: %0d samples over %0d setting phases, %0d register writes",
               samples_sent, RANDOM_PHASES + 3, reg_writes);
      $display("tb: %0d responses checked, %0d of them flagged saturated",
               responses_checked, saturated_seen);
      if (errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this sequence.
   initial begin : watchdog
      #(LIMIT_NS);
      $display("tb: done, errors");
      $finish;
   end

endmodule
